@@ design/ugci_pkg.sv @@
// Shared constants, types and helpers for the uniform grid cell indexer.
`default_nettype none

package ugci_pkg;

    localparam int MAX_CELLS_PER_AXIS = 256;

    // Widths that follow from the axis cell limit.
    localparam int NW    = $clog2(MAX_CELLS_PER_AXIS + 1);   // one axis count
    localparam int NXY_W = 2 * NW;                           // nx*ny
    localparam int TOP_W = 3 * NW;                           // nx*ny*nz

    // Fixed widths of the words on the ports.
    localparam int IDX_OUT_W = 25;
    localparam int CFG_W     = 32;
    localparam int CELLS_W   = 9;

    // Internal index width: wide enough for nx*ny*nz and for the port.
    localparam int IX_W = (TOP_W > IDX_OUT_W) ? TOP_W : IDX_OUT_W;

    // Axis coordinate: magnitude saturates at COORD_SAT, sign kept.
    localparam int COORD_SAT = 32768;
    localparam int QW        = 16;              // saturated magnitude
    localparam int CW        = QW + 1;          // signed coordinate

    // Product and sum widths of the linear index.
    localparam int PY_W  = CW + NW + 1;
    localparam int PZ_W  = CW + NXY_W + 1;
    localparam int SUM_W = PZ_W + 1;
    localparam int OFF_W = NXY_W + 1;

    typedef logic [2:0] t_cfg_idx;

    typedef enum logic [2:0] {
        CFG_ORIGIN_X,
        CFG_ORIGIN_Y,
        CFG_ORIGIN_Z,
        CFG_INV_CELL,
        CFG_CELLS_X,
        CFG_CELLS_Y,
        CFG_CELLS_Z
    } t_cfg_reg;

    typedef enum logic {
        FUNC_BIN,
        FUNC_NBR
    } t_func;

    // Zero count reads as one, oversized count saturates.
    function automatic logic [NW-1:0] eff_cells(input logic [CELLS_W-1:0] v);
        logic [NW-1:0] r;
        if (v == '0) begin
            r = NW'(1);
        end else if (32'(v) > 32'(MAX_CELLS_PER_AXIS)) begin
            r = NW'(MAX_CELLS_PER_AXIS);
        end else begin
            r = NW'(v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ design/uniform_grid_cell_indexer_core.sv @@
// Uniform grid cell indexer: point to cell index or neighborhood cell list.
`default_nettype none

// Channel    | Direction | Handshake            | Word
// -----------+-----------+----------------------+-----------------------------------------
// config     | in        | i_cfg_we             | i_cfg_index, i_cfg_data
// query      | in        | i_start & !o_busy    | i_func, i_point_x/y/z
// result     | out       | o_valid (one cycle)  | o_cell_index, o_last
//
// A bin query yields one word; a neighborhood query yields 1..27 words, one per
// cycle, from the enumeration register at the end of the pipe. A new query can
// enter every cycle while o_busy is low. o_busy rises only when the enumerator
// is mid-run and all eight stages behind it hold queries; the result side has no
// back-pressure.
// Reset (synchronous, active low) empties the pipe and restores register defaults.

module uniform_grid_cell_indexer_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  ugci_pkg::t_cfg_idx                  i_cfg_index,
    input  logic [ugci_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic                                i_func,
    input  logic signed [31:0]                  i_point_x,
    input  logic signed [31:0]                  i_point_y,
    input  logic signed [31:0]                  i_point_z,
    output logic                                o_valid,
    output logic [ugci_pkg::IDX_OUT_W-1:0]      o_cell_index,
    output logic                                o_last
);
    import ugci_pkg::*;

    // ---------------------------------------------------------------
    // Configuration registers. Cell counts are stored already limited.
    // nx*ny and nx*ny*nz are registered in turn. Config must be written
    // only while idle (not enforced here), so no query sees them stale.
    // ---------------------------------------------------------------
    logic signed [31:0]  r_org [3];
    logic [31:0]         r_inv;
    logic [NW-1:0]       r_n [3];
    logic [NXY_W-1:0]    r_nxy;
    logic [TOP_W-1:0]    r_top;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_org[a] <= '0;
                r_n[a]   <= NW'(1);
            end
            r_inv <= 32'd65536;
            r_nxy <= NXY_W'(1);
            r_top <= TOP_W'(1);
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_index))
                    CFG_ORIGIN_X: r_org[0] <= $signed(i_cfg_data);
                    CFG_ORIGIN_Y: r_org[1] <= $signed(i_cfg_data);
                    CFG_ORIGIN_Z: r_org[2] <= $signed(i_cfg_data);
                    CFG_INV_CELL: r_inv    <= i_cfg_data;
                    CFG_CELLS_X:  r_n[0]   <= eff_cells(i_cfg_data[CELLS_W-1:0]);
                    CFG_CELLS_Y:  r_n[1]   <= eff_cells(i_cfg_data[CELLS_W-1:0]);
                    CFG_CELLS_Z:  r_n[2]   <= eff_cells(i_cfg_data[CELLS_W-1:0]);
                    default: ;
                endcase
            end
            r_nxy <= NXY_W'(r_n[0]) * NXY_W'(r_n[1]);
            r_top <= TOP_W'(r_nxy) * TOP_W'(r_n[2]);
        end
    end

    // ---------------------------------------------------------------
    // Pipeline flow control. Stage k loads from stage k-1 whenever it is
    // empty or its own word moves on; the enumerator takes a new word when
    // it is idle or emitting its last result.
    // ---------------------------------------------------------------
    localparam int NSTG = 8;

    logic [NSTG:1]   r_v;
    logic [NSTG+1:1] rdy;
    logic            r_ev;
    logic            en_last;
    logic            en_take;

    always_comb begin
        en_take       = !r_ev || en_last;
        rdy[NSTG + 1] = en_take;
        for (int k = NSTG; k >= 1; k--) begin
            rdy[k] = !r_v[k] || rdy[k + 1];
        end
    end

    assign o_busy = !rdy[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[1]) begin
                r_v[1] <= i_start;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= r_v[k - 1];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Per-axis datapath, stages 1..5.
    //   s1: offset from origin (33 bit signed)
    //   s2: sign and magnitude
    //   s3: two partial products of magnitude * inv_cell_size
    //   s4: sum, take integer part, saturate at COORD_SAT
    //   s5: signed coordinate, or clamped coordinate and edge flags
    // ---------------------------------------------------------------
    logic signed [31:0] pt [3];
    assign pt[0] = i_point_x;
    assign pt[1] = i_point_y;
    assign pt[2] = i_point_z;

    logic signed [32:0] r_s1_diff [3];
    logic               r_s1_func;
    logic               r_s2_neg [3];
    logic [32:0]        r_s2_mag [3];
    logic               r_s2_func;
    logic               r_s3_neg [3];
    logic [48:0]        r_s3_ph [3];
    logic [47:0]        r_s3_pl [3];
    logic               r_s3_func;
    logic               r_s4_neg [3];
    logic [QW-1:0]      r_s4_q [3];
    logic               r_s4_func;
    logic signed [CW-1:0] r_s5_m [3];
    logic [2:0]         r_s5_lo;
    logic [2:0]         r_s5_hi;

    logic [64:0]          s4_sum [3];
    logic [32:0]          s4_q [3];
    logic [QW-1:0]        n_s4_q [3];
    logic [NW-1:0]        s5_nm1 [3];
    logic [NW-1:0]        s5_cc [3];
    logic signed [CW-1:0] s5_cs [3];
    logic signed [CW-1:0] n_s5_m [3];
    logic [2:0]           n_s5_lo;
    logic [2:0]           n_s5_hi;
    logic                 s5_nbr;

    always_comb begin
        s5_nbr = (r_s4_func == FUNC_NBR);
        for (int a = 0; a < 3; a++) begin
            s4_sum[a] = {r_s3_ph[a], 16'b0} + 65'(r_s3_pl[a]);
            s4_q[a]   = s4_sum[a][64:32];
            n_s4_q[a] = (s4_q[a] > 33'(COORD_SAT)) ? QW'(COORD_SAT) : s4_q[a][QW-1:0];

            // clamp into 0..n-1 straight from sign and magnitude
            s5_nm1[a] = r_n[a] - NW'(1);
            if (r_s4_neg[a] || r_s4_q[a] == '0) begin
                s5_cc[a] = '0;
            end else if (r_s4_q[a] >= r_n[a]) begin
                s5_cc[a] = s5_nm1[a];
            end else begin
                s5_cc[a] = NW'(r_s4_q[a]);
            end
            s5_cs[a]   = r_s4_neg[a] ? -$signed({1'b0, r_s4_q[a]})
                                     : $signed({1'b0, r_s4_q[a]});
            n_s5_m[a]  = s5_nbr ? $signed(CW'(s5_cc[a])) : s5_cs[a];
            n_s5_lo[a] = s5_nbr && (s5_cc[a] != '0);
            n_s5_hi[a] = s5_nbr && (s5_cc[a] != s5_nm1[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_s1_func <= i_func;
            for (int a = 0; a < 3; a++) begin
                r_s1_diff[a] <= $signed({pt[a][31], pt[a]}) - $signed({r_org[a][31], r_org[a]});
            end
        end
        if (rdy[2]) begin
            r_s2_func <= r_s1_func;
            for (int a = 0; a < 3; a++) begin
                r_s2_neg[a] <= r_s1_diff[a][32];
                r_s2_mag[a] <= r_s1_diff[a][32] ? 33'(-r_s1_diff[a]) : 33'(r_s1_diff[a]);
            end
        end
        if (rdy[3]) begin
            r_s3_func <= r_s2_func;
            for (int a = 0; a < 3; a++) begin
                r_s3_neg[a] <= r_s2_neg[a];
                r_s3_ph[a]  <= 49'(r_s2_mag[a][32:16]) * 49'(r_inv);
                r_s3_pl[a]  <= 48'(r_s2_mag[a][15:0]) * 48'(r_inv);
            end
        end
        if (rdy[4]) begin
            r_s4_func <= r_s3_func;
            for (int a = 0; a < 3; a++) begin
                r_s4_neg[a] <= r_s3_neg[a];
                r_s4_q[a]   <= n_s4_q[a];
            end
        end
        if (rdy[5]) begin
            r_s5_lo <= n_s5_lo;
            r_s5_hi <= n_s5_hi;
            for (int a = 0; a < 3; a++) begin
                r_s5_m[a] <= n_s5_m[a];
            end
        end
    end

    // ---------------------------------------------------------------
    // Linear index, stages 6..8.
    //   s6: y*nx and z*nx*ny
    //   s7: three-way sum; offset of the first neighbor; per-axis counts
    //   s8: first index, clamped to 0..nx*ny*nz (bins only ever hit it)
    // ---------------------------------------------------------------
    logic signed [CW-1:0]    r_s6_mx;
    logic signed [PY_W-1:0]  r_s6_py;
    logic signed [PZ_W-1:0]  r_s6_pz;
    logic [2:0]              r_s6_lo;
    logic [2:0]              r_s6_hi;
    logic signed [SUM_W-1:0] r_s7_sum;
    logic [OFF_W-1:0]        r_s7_off;
    logic [1:0]              r_s7_cnt [3];
    logic [IX_W-1:0]         r_s8_idx;
    logic [1:0]              r_s8_cnt [3];

    logic signed [SUM_W-1:0] s8_d;
    logic signed [SUM_W-1:0] s8_top;
    logic [IX_W-1:0]         n_s8_idx;

    always_comb begin
        s8_d   = r_s7_sum - $signed(SUM_W'(r_s7_off));
        s8_top = $signed(SUM_W'(r_top));
        if (s8_d < 0) begin
            n_s8_idx = '0;
        end else if (s8_d > s8_top) begin
            n_s8_idx = IX_W'(r_top);
        end else begin
            n_s8_idx = IX_W'(s8_d);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[6]) begin
            r_s6_mx <= r_s5_m[0];
            r_s6_py <= PY_W'(r_s5_m[1]) * PY_W'($signed({1'b0, r_n[0]}));
            r_s6_pz <= PZ_W'(r_s5_m[2]) * PZ_W'($signed({1'b0, r_nxy}));
            r_s6_lo <= r_s5_lo;
            r_s6_hi <= r_s5_hi;
        end
        if (rdy[7]) begin
            r_s7_sum <= SUM_W'(r_s6_mx) + SUM_W'(r_s6_py) + SUM_W'(r_s6_pz);
            r_s7_off <= OFF_W'(r_s6_lo[0])
                      + (r_s6_lo[1] ? OFF_W'(r_n[0]) : OFF_W'(0))
                      + (r_s6_lo[2] ? OFF_W'(r_nxy)  : OFF_W'(0));
            for (int a = 0; a < 3; a++) begin
                r_s7_cnt[a] <= {1'b0, r_s6_lo[a]} + {1'b0, r_s6_hi[a]};
            end
        end
        if (rdy[8]) begin
            r_s8_idx <= n_s8_idx;
            for (int a = 0; a < 3; a++) begin
                r_s8_cnt[a] <= r_s7_cnt[a];
            end
        end
    end

    // ---------------------------------------------------------------
    // Enumerator: walks x outermost, z innermost, one word per cycle.
    // r_px holds the index at the low y/z corner of the current x slice,
    // r_py the index at the low z end of the current row.
    // ---------------------------------------------------------------
    logic [IX_W-1:0] r_idx;
    logic [IX_W-1:0] r_py;
    logic [IX_W-1:0] r_px;
    logic [1:0]      r_xrem;
    logic [1:0]      r_yrem;
    logic [1:0]      r_zrem;
    logic [1:0]      r_ycnt;
    logic [1:0]      r_zcnt;

    assign en_last = (r_xrem == '0) && (r_yrem == '0) && (r_zrem == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev <= 1'b0;
        end else if (en_take) begin
            r_ev <= r_v[NSTG];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_take) begin
            r_idx  <= r_s8_idx;
            r_py   <= r_s8_idx;
            r_px   <= r_s8_idx;
            r_xrem <= r_s8_cnt[0];
            r_yrem <= r_s8_cnt[1];
            r_zrem <= r_s8_cnt[2];
            r_ycnt <= r_s8_cnt[1];
            r_zcnt <= r_s8_cnt[2];
        end else if (r_zrem != '0) begin
            r_zrem <= r_zrem - 2'd1;
            r_idx  <= r_idx + IX_W'(r_nxy);
        end else if (r_yrem != '0) begin
            r_yrem <= r_yrem - 2'd1;
            r_zrem <= r_zcnt;
            r_py   <= r_py + IX_W'(r_n[0]);
            r_idx  <= r_py + IX_W'(r_n[0]);
        end else begin
            r_xrem <= r_xrem - 2'd1;
            r_yrem <= r_ycnt;
            r_zrem <= r_zcnt;
            r_px   <= r_px + IX_W'(1);
            r_py   <= r_px + IX_W'(1);
            r_idx  <= r_px + IX_W'(1);
        end
    end

    assign o_valid      = r_ev;
    assign o_cell_index = r_idx[IDX_OUT_W-1:0];
    assign o_last       = en_last;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result word after reset");

    a_run_unbroken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |=> o_valid)
        else $error("neighborhood run broken before last word");

    // every step of a run moves along some axis, so the index never repeats
    a_idx_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |=> r_idx != $past(r_idx))
        else $error("neighborhood index repeated");

    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |-> r_ev && !en_last && (&r_v))
        else $error("busy without a full pipe behind a running enumerator");

endmodule

`default_nettype wire
